### design/bdq_pkg.sv
// Shared types and constants for the bounded deque with positional access.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int unsigned BDQ_DEPTH = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned OCC_W     = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Per-transaction result fields that travel alongside the memory read.
  typedef struct packed {
    status_e          status;
    logic             rd_valid;
    logic [OCC_W-1:0] occupancy;
  } meta_t;

endpackage

### design/bdq_ram.sv
// Generic single-port RAM with registered, enable-held read data.
`timescale 1ns / 1ps

module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/bdq_ctrl.sv
// Front pointer, entry count, request decode and memory command generation.
`timescale 1ns / 1ps

module bdq_ctrl
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = BDQ_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [OP_W-1:0]           opcode_i,
  input  logic [DATA_W-1:0]         value_i,
  input  logic [POS_W-1:0]          position_i,
  output logic                      ram_we_o,
  output logic                      ram_re_o,
  output logic [$clog2(DEPTH)-1:0]  ram_addr_o,
  output logic [DATA_W-1:0]         ram_wdata_o,
  output meta_t                     meta_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [AW-1:0]       front_q, front_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       front_inc, front_dec;
  logic [AW-1:0]       offset;
  logic [AW:0]         slot_sum;
  logic [AW-1:0]       slot_addr;
  logic [CW-1:0]       count_m1;
  logic [POS_W+AW-1:0] pos_ext;
  logic [POS_W+CW-1:0] pos_cmp, count_cmp;
  logic [CW+OCC_W-1:0] occ_ext;
  logic                full, empty, in_range;
  opcode_e             op;
  status_e             status;
  logic                ok;

  assign op        = opcode_e'(opcode_i);
  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign count_m1  = count_q - CW'(1);
  assign pos_ext   = {{AW{1'b0}}, position_i};
  assign pos_cmp   = {{CW{1'b0}}, position_i};
  assign count_cmp = {{POS_W{1'b0}}, count_q};
  assign in_range  = (pos_cmp < count_cmp);

  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);

  // Offset from the front for the back-end and positional requests.
  always_comb begin
    case (op)
      OP_PUSH_BACK: offset = count_q[AW-1:0];
      OP_POP_BACK:  offset = count_m1[AW-1:0];
      default:      offset = pos_ext[AW-1:0];
    endcase
  end

  // Wrap front + offset into the ring; for every request carried out, both terms stay below DEPTH.
  assign slot_sum  = {1'b0, front_q} + {1'b0, offset};
  assign slot_addr = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                                  : slot_sum[AW-1:0];

  always_comb begin
    front_d    = front_q;
    count_d    = count_q;
    status     = ST_OK;
    ram_we_o   = 1'b0;
    ram_re_o   = 1'b0;
    ram_addr_o = slot_addr;
    case (op)
      OP_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ram_we_o = accept_i;
          count_d  = count_q + CW'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ram_addr_o = front_dec;
          ram_we_o   = accept_i;
          front_d    = front_dec;
          count_d    = count_q + CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ram_re_o = accept_i;
          count_d  = count_m1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ram_addr_o = front_q;
          ram_re_o   = accept_i;
          front_d    = front_inc;
          count_d    = count_m1;
        end
      end
      OP_READ: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          ram_re_o = accept_i;
        end
      end
      OP_WRITE: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          ram_we_o = accept_i;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign ok      = (status == ST_OK);
  assign occ_ext = {{OCC_W{1'b0}}, count_d};

  assign ram_wdata_o      = value_i;
  assign meta_o.status    = status;
  assign meta_o.rd_valid  = ok && (op inside {OP_POP_BACK, OP_POP_FRONT, OP_READ});
  assign meta_o.occupancy = occ_ext[OCC_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

endmodule

### design/bounded_deque_with_index_top.sv
// Top level of the bounded deque with positional read and write.
`timescale 1ns / 1ps
//
// Usage
//   Request channel: in_valid_i / in_stall_o with opcode_i, value_i, position_i.
//   A transaction is taken at a rising edge with in_valid_i high, in_stall_o low.
//   Opcodes: push back, push front, pop back, pop front, read at position,
//   write at position (position counted from the front, zero based).
//   Result channel: out_valid_o / out_stall_i with status_o, read_value_o and
//   occupancy_o (entries held after the request). Exactly one result per request.
//   Each result passes the stage behind the memory, then the result register.
//   Throughput: one request per cycle unless stalled. Pointer and count update
//   at acceptance, so each request sees the one before it; the single memory
//   port is used at most once per request, either read or write, at acceptance.
//   Stall: the result register holds while out_stall_i is high; one more
//   request waits in the stage behind it, then in_stall_o rises until the
//   result register drains.
//   Reset: asynchronous, active low. Queue empty, front pointer zero, both
//   stages empty. Memory contents are not cleared; only written entries are
//   ever read back.
//   DEPTH may be any value from 2 to 4096; occupancy wraps modulo 128.

module bounded_deque_with_index_top
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = BDQ_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [OCC_W-1:0]         occupancy_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic              accept;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  meta_t             meta;

  // Stage behind the memory read: metadata waits for the read data.
  logic              s2_valid_q, s2_valid_d;
  meta_t             s2_meta_q;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic [STAT_W-1:0] status_q;
  logic [DATA_W-1:0] read_value_q;
  logic [OCC_W-1:0]  occupancy_q;

  // Advance the pending result when the result register is empty or draining.
  assign out_load   = s2_valid_q && (!out_valid_q || !out_stall_i);
  // Refuse a new request only while the stage behind the memory is stuck;
  // the memory read data is held because no new read is issued then.
  assign in_stall_o = s2_valid_q && !out_load;
  assign accept     = in_valid_i && !in_stall_o;

  bdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .meta_o      (meta)
  );

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (accept) begin
      s2_valid_d = 1'b1;
    end else if (out_load) begin
      s2_valid_d = 1'b0;
    end
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: capture metadata at acceptance, result at load.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_meta_q <= meta;
    end
    if (out_load) begin
      status_q     <= s2_meta_q.status;
      read_value_q <= s2_meta_q.rd_valid ? ram_rdata : '0;
      occupancy_q  <= s2_meta_q.occupancy;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_value_o = $signed(read_value_q);
  assign occupancy_o  = occupancy_q;

endmodule

### design/bdq_checker.sv
// Port-level assertions for the bounded deque, bound to its top level.
`timescale 1ns / 1ps

module bdq_checker
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = BDQ_DEPTH
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [STAT_W-1:0]        status_o,
  input logic signed [DATA_W-1:0] read_value_o,
  input logic [OCC_W-1:0]         occupancy_o
);

  // A stalled result stays and keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_value_o))
    else $error("result dropped or changed while stalled");

  // A refused request or failed access returns no data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> read_value_o == '0)
    else $error("refused request returned data");

  // A full refusal only happens with every entry held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> occupancy_o == OCC_W'(DEPTH))
    else $error("push refused while not full");

  // An empty refusal only happens on an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> occupancy_o == '0)
    else $error("pop refused while not empty");

  // Occupancy never exceeds the capacity; checked only for DEPTH below 128.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DEPTH >= 128) || (occupancy_o <= OCC_W'(DEPTH)))
    else $error("occupancy above capacity");

endmodule

bind bounded_deque_with_index_top bdq_checker #(
  .DEPTH (DEPTH)
) u_bdq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .read_value_o (read_value_o),
  .occupancy_o  (occupancy_o)
);

### test/bdq_result_checker.sv
// Result checker for the bounded deque: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module bdq_result_checker
  import bdq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [STAT_W-1:0]        status_i,
  input  logic signed [DATA_W-1:0] read_value_i,
  input  logic [OCC_W-1:0]         occupancy_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  typedef struct packed {
    status_e                 status;
    logic signed [DATA_W-1:0] word;
    logic [OCC_W-1:0]        occupancy;
  } deque_reply_t;

  logic signed [DATA_W-1:0] ring [BDQ_DEPTH];
  int unsigned              head  = 0;
  int unsigned              count = 0;
  deque_reply_t             awaited_q [$];

  function automatic int unsigned slot(input int unsigned offset);
    return (head + offset) % BDQ_DEPTH;
  endfunction

  // Apply one request to the shadow deque and return the reply it earns.
  function automatic deque_reply_t deque_apply(input logic [OP_W-1:0] op,
                                               input logic signed [DATA_W-1:0] word,
                                               input logic [POS_W-1:0] pos);
    deque_reply_t r;
    r.status = ST_OK;
    r.word   = '0;
    case (op)
      OP_PUSH_BACK: begin
        if (count >= BDQ_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring[slot(count)] = word;
          count++;
        end
      end
      OP_PUSH_FRONT: begin
        if (count >= BDQ_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head = slot(BDQ_DEPTH - 1);
          ring[head] = word;
          count++;
        end
      end
      OP_POP_BACK: begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          count--;
          r.word = ring[slot(count)];
        end
      end
      OP_POP_FRONT: begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.word = ring[head];
          head = slot(1);
          count--;
        end
      end
      OP_READ: begin
        if (pos >= count) r.status = ST_RANGE;
        else r.word = ring[slot(pos)];
      end
      OP_WRITE: begin
        if (pos >= count) r.status = ST_RANGE;
        else ring[slot(pos)] = word;
      end
      default: ;
    endcase
    r.occupancy = count[OCC_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_reply_t want;
    if (!rst_ni) begin
      head  = 0;
      count = 0;
      awaited_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: result with nothing awaited: status %0d data %0d occupancy %0d",
                   $time, status_i, read_value_i, occupancy_i);
          fail_count_o++;
        end else begin
          want = awaited_q.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
            fail_count_o++;
          end
          if (read_value_i !== want.word) begin
            $display("%0t: read_value expected %0d actual %0d",
                     $time, want.word, read_value_i);
            fail_count_o++;
          end
          if (occupancy_i !== want.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d",
                     $time, want.occupancy, occupancy_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_q.push_back(deque_apply(opcode_i, value_i, position_i));
      pending_o = awaited_q.size();
    end
  end

endmodule

### test/bounded_deque_with_index_top_tb.sv
// Regression testbench top for the bounded deque: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module bounded_deque_with_index_top_tb;
  import bdq_pkg::*;

  // Opcodes outside the defined set; the block must ignore them.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_REQUESTS = 1330;
  localparam int CALM_REQUESTS   = 200;   // opening stretch with no idling on either side
  localparam int HOLD_AT         = 500;   // request index where the long receiver hold starts
  localparam int DRAIN_AT        = 900;   // request index where the sender waits for all results
  localparam int HOLD_CYCLES     = 200;
  localparam int WATCHDOG_LIMIT  = 4000;  // several times the longest legal quiet stretch
  localparam int TAIL_CYCLES     = 8;     // slack after the final drain

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} op_mix_e;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic [OP_W-1:0]          opcode_i     = OP_PUSH_BACK;
  logic signed [DATA_W-1:0] value_i      = '0;
  logic [POS_W-1:0]         position_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i  = 1'b0;
  logic [STAT_W-1:0]        status_o;
  logic signed [DATA_W-1:0] read_value_o;
  logic [OCC_W-1:0]         occupancy_o;

  int fail_count;
  int pending;

  bit src_idle_on  = 1'b0;  // touched by the stimulus process only
  bit sink_idle_on = 1'b0;
  int hold_reqs    = 0;     // bumped by the stimulus process only
  int hold_seen    = 0;     // owned by the receiver
  int hold_left    = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bounded_deque_with_index_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .read_value_o(read_value_o),
    .occupancy_o (occupancy_o)
  );

  bdq_result_checker checker_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status_o),
    .read_value_i(read_value_o),
    .occupancy_i (occupancy_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Receiver: a requested hold keeps stall high, counted down here in hold_left;
  // otherwise stall at random about one cycle in ten once idling is enabled.
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen   <= hold_reqs;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= sink_idle_on && ($urandom_range(0, 99) < 10);
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("bounded_deque_with_index_top regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one request and hold it until the block takes it. Valid stays high
  // when the next request follows at once, so it is never lowered and raised
  // in the same step.
  task automatic offer_request(input logic [OP_W-1:0] op,
                               input logic [DATA_W-1:0] word,
                               input logic [POS_W-1:0] pos);
    while (src_idle_on && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= word;
    position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Lower valid and wait until every awaited result has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Draw one request from the given mix. Push-heavy runs reach the full queue
  // and wrap the front pointer; pop-heavy runs reach the empty queue.
  task automatic draw_request(input op_mix_e mix,
                              output logic [OP_W-1:0] op,
                              output logic [DATA_W-1:0] word,
                              output logic [POS_W-1:0] pos);
    int roll;
    int push_pct;
    int pop_pct;
    int pick;
    push_pct = (mix == MIX_GROW) ? 75 : (mix == MIX_SHRINK) ? 8 : 35;
    pop_pct  = (mix == MIX_SHRINK) ? 75 : (mix == MIX_GROW) ? 8 : 35;
    roll = $urandom_range(0, 99);
    if (roll < 2)
      op = roll[0] ? OP_SPARE_7 : OP_SPARE_6;
    else if (roll < 2 + push_pct)
      op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    else if (roll < 2 + push_pct + pop_pct)
      op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    else
      op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;

    pick = $urandom_range(0, 15);
    case (pick)
      0: word = 32'h8000_0000;
      1: word = 32'h7FFF_FFFF;
      2: word = 32'h0000_0000;
      3: word = 32'hFFFF_FFFF;
      default: word = $urandom;
    endcase

    pick = $urandom_range(0, 3);
    if (pick < 2) pos = POS_W'($urandom_range(0, 7));
    else if (pick == 2) pos = POS_W'($urandom_range(0, 63));
    else pos = POS_W'(63 - $urandom_range(0, 7));
  endtask

  initial begin
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] word;
    logic [POS_W-1:0]  pos;
    op_mix_e           mix;
    int                run_left;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: refused requests on the empty queue, ignored opcodes.
    offer_request(OP_POP_BACK, 32'h0, 6'd0);
    offer_request(OP_POP_FRONT, 32'h0, 6'd0);
    offer_request(OP_READ, 32'h0, 6'd0);
    offer_request(OP_WRITE, 32'h1234_5678, 6'd0);
    offer_request(OP_SPARE_6, 32'hFFFF_FFFF, 6'd63);
    offer_request(OP_SPARE_7, 32'hFFFF_FFFF, 6'd63);
    // Extremes of the data word; push front with the front pointer at zero wraps it.
    offer_request(OP_PUSH_BACK, 32'h7FFF_FFFF, 6'd0);
    offer_request(OP_PUSH_FRONT, 32'h8000_0000, 6'd0);
    offer_request(OP_PUSH_BACK, 32'h0000_0000, 6'd0);
    offer_request(OP_PUSH_FRONT, 32'hFFFF_FFFF, 6'd0);
    // Positional access: first, last, one past the end, the top position.
    offer_request(OP_READ, 32'h0, 6'd0);
    offer_request(OP_READ, 32'h0, 6'd3);
    offer_request(OP_READ, 32'h0, 6'd4);
    offer_request(OP_READ, 32'h0, 6'd63);
    offer_request(OP_WRITE, 32'h5555_5555, 6'd2);
    offer_request(OP_READ, 32'h0, 6'd2);
    offer_request(OP_WRITE, 32'hAAAA_AAAA, 6'd63);
    // Drain from both ends, then one pop too many.
    offer_request(OP_POP_FRONT, 32'h0, 6'd0);
    offer_request(OP_POP_BACK, 32'h0, 6'd0);
    offer_request(OP_POP_BACK, 32'h0, 6'd0);
    offer_request(OP_POP_FRONT, 32'h0, 6'd0);
    offer_request(OP_POP_FRONT, 32'h0, 6'd0);

    // Random: runs of a chosen mix; the first run is push-heavy.
    mix      = MIX_GROW;
    run_left = 90;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == CALM_REQUESTS) begin
        src_idle_on  = 1'b1;
        sink_idle_on <= 1'b1;
      end
      if (n == HOLD_AT) hold_reqs <= hold_reqs + 1;
      if (n == DRAIN_AT) wait_drained();
      if (run_left == 0) begin
        mix      = op_mix_e'($urandom_range(0, 2));
        run_left = $urandom_range(20, 80);
      end
      run_left--;
      draw_request(mix, op, word, pos);
      offer_request(op, word, pos);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("bounded_deque_with_index_top regression: pass");
    end else begin
      $display("bounded_deque_with_index_top regression: fail");
    end
    $finish;
  end

endmodule

### bounded_deque_with_index_top.f
design/bdq_pkg.sv
design/bdq_ram.sv
design/bdq_ctrl.sv
design/bounded_deque_with_index_top.sv
design/bdq_checker.sv
test/bdq_result_checker.sv
test/bounded_deque_with_index_top_tb.sv
